@@ rtl/gcbh_pkg.sv @@
// shared types and constants for the grid cell box hit histogram
package gcbh_pkg;

   localparam int COORD_W     = 13;  // pixel coordinates and sizes
   localparam int GRID_W      = 3;   // grid row and column registers
   localparam int COUNT_W     = 16;  // saturating cell counts
   localparam int HITS_W      = 16;  // hit mask, bit row*max_cols+col
   localparam int POS_W       = 2;   // reported row and column
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS    = 2'd3;

   localparam logic [COORD_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [COORD_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;
   localparam logic [GRID_W-1:0]  GRID_ROWS_RESET    = 3'd4;
   localparam logic [GRID_W-1:0]  GRID_COLS_RESET    = 3'd4;

   typedef struct packed {
      logic               clear_counts;
      logic [COORD_W-1:0] box_x;
      logic [COORD_W-1:0] box_y;
      logic [COORD_W-1:0] box_width;
      logic [COORD_W-1:0] box_height;
   } req_payload_type;

   typedef struct packed {
      logic [HITS_W-1:0]  cell_hits;
      logic               best_valid;
      logic [POS_W-1:0]   best_row;
      logic [POS_W-1:0]   best_col;
      logic [COUNT_W-1:0] best_count;
   } rsp_payload_type;

endpackage

@@ rtl/grid_cell_box_hit_histogram.sv @@
// top level: box corner hits per grid cell, saturating counts and running argmax
// Each accepted box beat sweeps the cell count memory once, one entry a cycle in
// row-major order: read, add one where a box corner falls in the cell, write back,
// and fold the new count into the argmax. A box holds the input stalled from
// acceptance through the sweep, drain and done states until the next box can be
// taken, as the count memory has a single read and write port. The result beat
// sits in an output register, so the sweep of the next box never waits on a
// stalled result until that box is finished. Cell width and height come from a
// bit-serial divider that runs after reset and after every configuration write;
// req_stall stays high while it runs. Configuration writes are always taken
// (csr_ready is tied high) and should only be made while no box is in flight.
// Counts start at zero after reset through per-entry valid flags, so there is
// no clearing pass.
module grid_cell_box_hit_histogram #(
   parameter int MAX_ROWS = 4,
   parameter int MAX_COLS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  gcbh_pkg::req_payload_type            req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gcbh_pkg::rsp_payload_type            rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gcbh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gcbh_pkg::COORD_W-1:0]         csr_wdata
);
   import gcbh_pkg::*;

   // cells beyond the width of the hit mask are never addressed
   localparam int CELLS   = MAX_ROWS * MAX_COLS;
   localparam int SLOTS   = (CELLS < HITS_W) ? CELLS : HITS_W;
   localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int GSZ_W   = ($clog2(DIM_MAX + 1) > GRID_W) ? $clog2(DIM_MAX + 1) : GRID_W;
   localparam int PT_W    = COORD_W + 1;   // corner coordinates, x + w
   localparam int EXT_W   = COORD_W + 2;   // cell limits, x0 + cw

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // point p lies in [lo, lim - 1), written without going negative
   function automatic logic span_hit(input logic [PT_W-1:0] p, input logic [PT_W-1:0] lo,
                                     input logic [EXT_W-1:0] lim);
      return (p >= lo) && ((EXT_W'(p) + EXT_W'(1)) < lim);
   endfunction

   // configuration registers
   logic [COORD_W-1:0] cfg_width_ff, cfg_height_ff;
   logic [GRID_W-1:0]  cfg_rows_ff, cfg_cols_ff;
   logic               div_start_ff;
   logic               div_busy_w, div_busy_h;
   logic               cfg_busy;
   logic [COORD_W-1:0] cw_q, ch_q;
   logic [GSZ_W-1:0]   rows_use, cols_use;

   // sweep control
   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [PT_W-1:0]    x0_ff, x0_in, y0_ff, y0_in;
   logic               req_accept;
   logic               rsp_load;

   // latched box
   logic               clear_ff;
   logic [PT_W-1:0]    bx_ff, bxw_ff, by_ff, byh_ff;

   // read stage of the sweep
   logic               in_use, cell_hit;
   logic [EXT_W-1:0]   x_lim, y_lim;
   logic               s1_valid_ff, s1_valid_in;

   // modify and write stage
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               s1_hit_ff, s1_use_ff, s1_mem_valid_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [COUNT_W-1:0] rd_data_ff;
   logic [COUNT_W-1:0] base_cnt, new_cnt;

   // count memory with per-entry valid flags
   logic [COUNT_W-1:0] count_mem [SLOTS];
   logic [SLOTS-1:0]   ent_valid_ff;

   // running results
   logic [SLOTS-1:0]   hits_ff;
   logic [COUNT_W-1:0] best_cnt_ff;
   logic               best_valid_ff;
   logic [POS_W-1:0]   best_row_ff, best_col_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= IMAGE_WIDTH_RESET;
         cfg_height_ff <= IMAGE_HEIGHT_RESET;
         cfg_rows_ff   <= GRID_ROWS_RESET;
         cfg_cols_ff   <= GRID_COLS_RESET;
         div_start_ff  <= 1'b1;
      end else begin
         div_start_ff <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata;
               CSR_GRID_ROWS:    cfg_rows_ff   <= csr_wdata[GRID_W-1:0];
               CSR_GRID_COLS:    cfg_cols_ff   <= csr_wdata[GRID_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // zero grid size counts as one, anything above the maximum as the maximum
   always_comb begin
      if (cfg_rows_ff == '0) begin
         rows_use = GSZ_W'(1);
      end else if (GSZ_W'(cfg_rows_ff) > GSZ_W'(MAX_ROWS)) begin
         rows_use = GSZ_W'(MAX_ROWS);
      end else begin
         rows_use = GSZ_W'(cfg_rows_ff);
      end
      if (cfg_cols_ff == '0) begin
         cols_use = GSZ_W'(1);
      end else if (GSZ_W'(cfg_cols_ff) > GSZ_W'(MAX_COLS)) begin
         cols_use = GSZ_W'(MAX_COLS);
      end else begin
         cols_use = GSZ_W'(cfg_cols_ff);
      end
   end

   // cell sizes; the clamped sizes never exceed the grid register range
   gcbh_div u_div_width (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (cfg_width_ff),
      .divisor  (GRID_W'(cols_use)),
      .busy     (div_busy_w),
      .quotient (cw_q)
   );

   gcbh_div u_div_height (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (cfg_height_ff),
      .divisor  (GRID_W'(rows_use)),
      .busy     (div_busy_h),
      .quotient (ch_q)
   );

   assign cfg_busy = div_start_ff || div_busy_w || div_busy_h;

   // ---------------------------------------------------------------- sweep control
   assign req_stall  = (state_ff != ST_IDLE) || cfg_busy;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      s1_valid_in = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SWEEP;
               addr_in  = '0;
               row_in   = '0;
               col_in   = '0;
               x0_in    = '0;
               y0_in    = '0;
            end
         end
         ST_SWEEP: begin
            s1_valid_in = 1'b1;
            if (addr_ff == ADDR_W'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
               if (col_ff == COL_W'(MAX_COLS - 1)) begin
                  // next row of cells
                  col_in = '0;
                  row_in = row_ff + ROW_W'(1);
                  x0_in  = '0;
                  y0_in  = y0_ff + PT_W'(ch_q);
               end else begin
                  col_in = col_ff + COL_W'(1);
                  x0_in  = x0_ff + PT_W'(cw_q);
               end
            end
         end
         ST_DRAIN: begin
            // last entry is being written back
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
      end
      addr_ff <= addr_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      x0_ff   <= x0_in;
      y0_ff   <= y0_in;
   end

   // box corners, x + w and y + h kept one bit wider
   always_ff @(posedge clock) begin
      if (req_accept) begin
         clear_ff <= req_data.clear_counts;
         bx_ff    <= PT_W'(req_data.box_x);
         by_ff    <= PT_W'(req_data.box_y);
         bxw_ff   <= PT_W'(req_data.box_x) + PT_W'(req_data.box_width);
         byh_ff   <= PT_W'(req_data.box_y) + PT_W'(req_data.box_height);
      end
   end

   // ---------------------------------------------------------------- read stage
   // the four corners are every pairing of the two x and two y values
   always_comb begin
      in_use   = (GSZ_W'(row_ff) < rows_use) && (GSZ_W'(col_ff) < cols_use);
      x_lim    = EXT_W'(x0_ff) + EXT_W'(cw_q);
      y_lim    = EXT_W'(y0_ff) + EXT_W'(ch_q);
      cell_hit = in_use
               && (span_hit(bx_ff, x0_ff, x_lim) || span_hit(bxw_ff, x0_ff, x_lim))
               && (span_hit(by_ff, y0_ff, y_lim) || span_hit(byh_ff, y0_ff, y_lim));
   end

   always_ff @(posedge clock) begin
      rd_data_ff      <= count_mem[addr_ff];
      s1_mem_valid_ff <= ent_valid_ff[addr_ff];
      s1_addr_ff      <= addr_ff;
      s1_hit_ff       <= cell_hit;
      s1_use_ff       <= in_use;
      s1_row_ff       <= row_ff;
      s1_col_ff       <= col_ff;
   end

   // ---------------------------------------------------------------- modify and write
   always_comb begin
      base_cnt = (clear_ff || !s1_mem_valid_ff) ? '0 : rd_data_ff;
      new_cnt  = (s1_hit_ff && (base_cnt != '1)) ? base_cnt + COUNT_W'(1) : base_cnt;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         count_mem[s1_addr_ff] <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
      end else if (s1_valid_ff) begin
         ent_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // argmax in row-major order, strict compare keeps the first of equal counts
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hits_ff       <= '0;
         best_cnt_ff   <= '0;
         best_valid_ff <= 1'b0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
      end else if (s1_valid_ff) begin
         if (s1_hit_ff) begin
            hits_ff[s1_addr_ff] <= 1'b1;
         end
         if (s1_use_ff && (new_cnt > best_cnt_ff)) begin
            best_cnt_ff   <= new_cnt;
            best_valid_ff <= 1'b1;
            best_row_ff   <= POS_W'(s1_row_ff);
            best_col_ff   <= POS_W'(s1_col_ff);
         end
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.cell_hits  <= HITS_W'(hits_ff);
         rsp_data_ff.best_valid <= best_valid_ff;
         rsp_data_ff.best_row   <= best_row_ff;
         rsp_data_ff.best_col   <= best_col_ff;
         rsp_data_ff.best_count <= best_cnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/gcbh_div.sv @@
// restoring divider of an image dimension by a small grid size, one bit a cycle
module gcbh_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gcbh_pkg::COORD_W-1:0]   dividend,
   input  logic [gcbh_pkg::GRID_W-1:0]    divisor,
   output logic                           busy,
   output logic [gcbh_pkg::COORD_W-1:0]   quotient
);
   import gcbh_pkg::*;

   localparam int STEP_W = $clog2(COORD_W + 1);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [GRID_W-1:0]  rem_ff, rem_in;
   logic [COORD_W-1:0] quot_ff, quot_in;
   logic [GRID_W:0]    trial;

   always_comb begin
      trial   = {rem_ff, quot_ff[COORD_W-1]};
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         step_in = STEP_W'(COORD_W);
         rem_in  = '0;
         quot_in = dividend;
      end else if (step_ff != '0) begin
         step_in = step_ff - STEP_W'(1);
         if (trial >= {1'b0, divisor}) begin
            rem_in  = GRID_W'(trial - {1'b0, divisor});
            quot_in = {quot_ff[COORD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[GRID_W-1:0];
            quot_in = {quot_ff[COORD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign busy     = (step_ff != '0);
   assign quotient = quot_ff;

endmodule

@@ rtl/gcbh_checker.sv @@
// port-level checks for the grid cell box hit histogram, bound to the top level
module gcbh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input gcbh_pkg::rsp_payload_type   rsp_data
);
   import gcbh_pkg::*;

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one box at a time: the input closes right after a beat is taken
   a_req_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second box taken during a sweep");

   // no count above zero gives an all-zero argmax
   a_empty_argmax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.best_valid |->
         rsp_data.best_count == '0 && rsp_data.best_row == '0 && rsp_data.best_col == '0)
      else $error("argmax reported without a valid count");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.best_valid |-> rsp_data.best_count != '0)
      else $error("valid argmax with zero count");

   // a hit cell has just been counted, so some count is above zero
   a_hit_implies_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cell_hits != '0 |-> rsp_data.best_valid)
      else $error("cell hit without a valid argmax");

endmodule

bind grid_cell_box_hit_histogram gcbh_checker u_gcbh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
